// ----- design/fs_pkg.sv -----
// Shared constants, types and codes for the frequency stack.
package fs_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = CNT_W + VALUE_W;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_PUSH_OK   = 2'd0;
    localparam logic [1:0] STATUS_POP_OK    = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;
    localparam logic [1:0] STATUS_POP_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } fs_state_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } fs_mem_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] pop_value;
        logic [1:0]         status;
    } fs_result_t;

endpackage

// ----- design/fs_req_if.sv -----
// Request channel: operation and push value with valid/ready.
interface fs_req_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// ----- design/fs_rsp_if.sv -----
// Result channel: popped value and status with valid/ready.
interface fs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pop_value;
    logic [1:0]         status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface

// ----- design/frequency_stack_core.sv -----
// Top level of the frequency stack: engine, entry memory and result register.
//
// Usage:
//   request  (sink):   operation (0 push, 1 pop) and push_value, valid/ready.
//   result   (source): pop_value and status, valid/ready, one per request.
//   Status: 0 push accepted, 1 pop done, 2 push dropped (full), 3 pop on empty.
// Operation (n = stored entries before the request):
//   push            : one memory read per stored entry to count matching
//                     values, then one write.
//   pop             : a scan of all n entries for the highest tag, then one
//                     read and one write per later entry to close the gap.
//   full/empty case : no memory access; the engine goes straight to its result.
//   One request is worked at a time; the single read port of the entry
//   memory sets the pace.
// Reset: asynchronous, active low; the store is empty afterwards. Memory
//   contents are not cleared, only entries below the occupancy are read.
// Stall: a finished result sits in the output register; the engine takes
//   the next request meanwhile, but holds its own result until the output
//   register frees up.
module frequency_stack_core
    import fs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fs_req_if.sink   request,
    fs_rsp_if.source result
);

    fs_mem_req_t        mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_ready;
    fs_result_t         res;

    logic               out_valid_reg;
    fs_result_t         out_data_reg;

    // entry store: {frequency tag, value}, index 0 is the oldest
    fs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    fs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .in_op     (request.operation),
        .in_value  (request.push_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // output register decouples the engine from a stalled receiver
    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.pop_value = out_data_reg.pop_value;
    assign result.status    = out_data_reg.status;

endmodule

// ----- design/fs_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module fs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/fs_engine.sv -----
// Sequencer: scans the entry memory to count, select and compact entries.
module fs_engine
    import fs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_op,
    input  logic [VALUE_W-1:0] in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output fs_result_t         res,
    output fs_mem_req_t        mem_req,
    input  logic [ENTRY_W-1:0] mem_rdata
);

    fs_state_t          state_reg, state_next;
    logic               op_reg, op_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]   best_freq_reg, best_freq_next;
    logic [VALUE_W-1:0] best_val_reg, best_val_next;
    logic [1:0]         status_reg, status_next;

    logic [CNT_W-1:0]   rd_freq;
    logic [VALUE_W-1:0] rd_val;

    assign rd_freq = mem_rdata[ENTRY_W-1:VALUE_W];
    assign rd_val  = mem_rdata[VALUE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            occ_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        count_reg     <= count_next;
        best_idx_reg  <= best_idx_next;
        best_freq_reg <= best_freq_next;
        best_val_reg  <= best_val_next;
        status_reg    <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        occ_next       = occ_reg;
        addr_next      = addr_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        count_next     = count_reg;
        best_idx_next  = best_idx_reg;
        best_freq_next = best_freq_reg;
        best_val_next  = best_val_reg;
        status_next    = status_reg;
        mem_req        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next        = in_op;
                    val_next       = in_value;
                    addr_next      = '0;
                    count_next     = '0;
                    best_freq_next = '0;
                    if (in_op == OP_POP)
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next = STATUS_POP_EMPTY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (occ_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = STATUS_PUSH_FULL;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (addr_reg < occ_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = addr_reg[IDX_W-1:0];
                    rd_idx_next   = addr_reg[IDX_W-1:0];
                    rd_vld_next   = 1'b1;
                    addr_next     = addr_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (op_reg == OP_PUSH)
                    begin
                        if (rd_val == val_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (rd_freq >= best_freq_reg)
                    begin
                        // ascending scan: >= keeps the newest among equal tags
                        best_freq_next = rd_freq;
                        best_idx_next  = rd_idx_reg;
                        best_val_next  = rd_val;
                    end
                end
                if (addr_reg >= occ_reg && !rd_vld_reg)
                begin
                    if (op_reg == OP_PUSH)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = occ_reg[IDX_W-1:0];
                        mem_req.wdata = {count_reg + 1'b1, val_reg};
                        occ_next      = occ_reg + 1'b1;
                        status_next   = STATUS_PUSH_OK;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        addr_next   = CNT_W'(best_idx_reg) + 1'b1;
                        status_next = STATUS_POP_OK;
                        state_next  = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (addr_reg < occ_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = addr_reg[IDX_W-1:0];
                    rd_idx_next   = addr_reg[IDX_W-1:0];
                    rd_vld_next   = 1'b1;
                    addr_next     = addr_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = rd_idx_reg - 1'b1;
                    mem_req.wdata = mem_rdata;
                end
                if (addr_reg >= occ_reg && !rd_vld_reg)
                begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.pop_value = (status_reg == STATUS_POP_OK) ? best_val_reg : '0;
    assign res.status    = status_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && mem_req.we) |-> (CNT_W'(mem_req.waddr) < occ_reg))
        else $error("compaction write outside stored entries");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == OP_PUSH && occ_reg == CNT_W'(CAPACITY))
        |=> (state_reg == ST_DONE && status_reg == STATUS_PUSH_FULL
             && occ_reg == $past(occ_reg)))
        else $error("push on full not dropped");

    a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |-> (state_reg == ST_DONE))
        else $error("occupancy changed outside completion");

endmodule

// ----- sim/frequency_stack_core_tb.sv -----
// Testbench for the frequency stack: directed and random push/pop requests checked against a scoreboard.
module frequency_stack_core_tb;
    import fs_pkg::*;

    // Predictor of the stack plus a queue of expected results.
    class freq_stack_board;
        logic signed [31:0] vals [CAPACITY];
        int                 freqs [CAPACITY];
        int                 fill;
        fs_result_t         pending [$];
        int                 errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(logic op, logic signed [31:0] value);
            fs_result_t r;
            int count;
            int best;
            int best_freq;
            r.pop_value = '0;
            if (op == OP_PUSH) begin
                if (fill >= CAPACITY) begin
                    r.status = STATUS_PUSH_FULL;
                end
                else begin
                    count = 0;
                    for (int i = 0; i < fill; i++)
                        if (vals[i] == value)
                            count++;
                    vals[fill] = value;
                    freqs[fill] = count + 1;
                    fill++;
                    r.status = STATUS_PUSH_OK;
                end
            end
            else if (fill == 0) begin
                r.status = STATUS_POP_EMPTY;
            end
            else begin
                best = 0;
                best_freq = 0;
                // newest first; only a strictly higher tag takes over
                for (int i = fill - 1; i >= 0; i--)
                    if (freqs[i] > best_freq) begin
                        best_freq = freqs[i];
                        best = i;
                    end
                r.pop_value = vals[best];
                for (int i = best; i + 1 < fill; i++) begin
                    vals[i] = vals[i + 1];
                    freqs[i] = freqs[i + 1];
                end
                fill--;
                r.status = STATUS_POP_OK;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] value, logic [1:0] st);
            fs_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value %0d status %0d", $time, value, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.pop_value !== value) begin
                $display("%0t: pop_value expected %0d actual %0d", $time,
                         $signed(e.pop_value), value);
                errors++;
            end
            if (e.status !== st) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    fs_req_if request ();
    fs_rsp_if result ();

    frequency_stack_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request.sink),
        .result  (result.source)
    );

    freq_stack_board board;
    bit  req_idle_on;   // random gaps on the request side
    bit  rsp_idle_on;   // random stalls on the result side
    int  hold_off;      // cycles the result side refuses outright
    bit  driving_done;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Present one request until it is taken, with optional gaps before it.
    // valid stays high on return so back-to-back requests need no gap.
    task automatic send_request(logic op, logic signed [31:0] value);
        while (req_idle_on && $urandom_range(99) < 37) begin
            request.valid <= 1'b0;
            @(negedge clk);
        end
        request.valid <= 1'b1;
        request.operation <= op;
        request.push_value <= value;
        do
            @(posedge clk);
        while (!request.ready);
        board.note_request(op, value);
        @(negedge clk);
    endtask

    // Pause the sender until every queued result has come back.
    task automatic drain();
        request.valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom;
            default: return $urandom_range(7);   // few values, so tags climb
        endcase
    endfunction

    // Result side: sample at the rising edge, change ready at the falling edge.
    always @(posedge clk)
        if (rst_n && result.valid && result.ready)
            board.check_result(result.pop_value, result.status);

    always @(negedge clk)
    begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= !(rsp_idle_on && $urandom_range(99) < 37);
    end

    initial
    begin
        int pop_bias;
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        request.valid = 1'b0;
        request.operation = OP_PUSH;
        request.push_value = '0;
        result.ready = 1'b0;
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        hold_off = 0;
        driving_done = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, extremes, ties and a pop past empty
        send_request(OP_POP, 32'sd0);
        send_request(OP_PUSH, 32'sh8000_0000);
        send_request(OP_PUSH, 32'sh7fff_ffff);
        send_request(OP_PUSH, 32'sh8000_0000);
        send_request(OP_PUSH, -32'sd1);
        send_request(OP_PUSH, 32'sd0);
        for (int i = 0; i < 5; i++)
            send_request(OP_POP, 32'sh5555_aaaa);
        send_request(OP_POP, -32'sd1);
        drain();

        // receiver holds off while the sender keeps pushing: fills and overflows
        hold_off = 300;
        for (int i = 0; i < CAPACITY + 3; i++)
            send_request(OP_PUSH, 32'(i % 3));
        drain();
        for (int i = 0; i < CAPACITY + 1; i++)
            send_request(OP_POP, 32'sd0);
        drain();

        // random part: a stretch without idling, then idling on both sides
        for (int i = 0; i < 700; i++) begin
            if (i == 150) begin
                req_idle_on = 1'b1;
                rsp_idle_on = 1'b1;
            end
            if (i % 200 == 199)
                drain();
            // sweep the pop share so the stack wanders between empty and full
            pop_bias = (i / 100) % 2 ? 65 : 35;
            if ($urandom_range(99) < pop_bias)
                send_request(OP_POP, $urandom);
            else
                send_request(OP_PUSH, pick_value());
        end
        drain();
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
